// File: design/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg: shared types and constants for the UTF-16 to UTF-8 transcoder
// Holds the decoder result bundle and the UTF-8 marker prefixes.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int UNIT_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int HELD_W  = 10;
    localparam int SLOTS   = 4;
    localparam int SLOT_W  = 2;

    // Surrogate classes, matched on the top six bits of a unit
    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

    // UTF-8 lead and continuation prefixes
    localparam logic [7:0] LEAD2_PFX = 8'hC0;
    localparam logic [7:0] LEAD3_PFX = 8'hE0;
    localparam logic [7:0] LEAD4_PFX = 8'hF0;
    localparam logic [7:0] CONT_PFX  = 8'h80;

    // Supplementary-plane offset added to a surrogate pair
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

    // Result of decoding one code unit against the held surrogate
    typedef struct packed {
        logic                          emit;      // group of bytes produced
        logic [SLOT_W-1:0]             last_idx;  // index of the final byte
        logic [SLOTS-1:0][BYTE_W-1:0]  bytes;     // byte 0 goes out first
        logic                          pend;      // next pending flag
        logic [HELD_W-1:0]             held;      // next held high bits
    } u16u8_dec_t;

endpackage

// File: design/u16u8_decode.sv
// ----------------------------------------------------------------------------
// u16u8_decode: code unit classifier and UTF-8 encoder
// Combines a unit with the held surrogate state and builds the byte group.
// ----------------------------------------------------------------------------
module u16u8_decode (
    input  logic [15:0]             unit,
    input  logic                    pend,
    input  logic [9:0]              held,
    output u16u8_pkg::u16u8_dec_t   dec
);
    import u16u8_pkg::*;

    logic            is_zero;
    logic            is_low;
    logic            is_high;
    logic [CP_W-1:0] cp;

    // Classify the incoming unit
    assign is_zero = (unit == '0);
    assign is_low  = (unit[15:10] == LOW_SURR_TAG);
    assign is_high = (unit[15:10] == HIGH_SURR_TAG);

    // Resolve surrogate state and pick the code point
    always_comb
    begin
        dec          = '0;
        cp           = {{(CP_W-UNIT_W){1'b0}}, unit};
        if (is_zero)
        begin
            // terminator: drop everything held
        end
        else if (pend)
        begin
            if (is_low)
            begin
                dec.emit = 1'b1;
                cp       = SUPP_BASE + {1'b0, held, unit[9:0]};
            end
        end
        else if (is_high)
        begin
            dec.pend = 1'b1;
            dec.held = unit[9:0];
        end
        else if (!is_low)
        begin
            dec.emit = 1'b1;
        end

        // Encode the code point into up to four bytes
        if (cp[20:7] == '0)
        begin
            dec.last_idx = 2'd0;
            dec.bytes[0] = {1'b0, cp[6:0]};
        end
        else if (cp[20:11] == '0)
        begin
            dec.last_idx = 2'd1;
            dec.bytes[0] = LEAD2_PFX | {3'b000, cp[10:6]};
            dec.bytes[1] = CONT_PFX  | {2'b00, cp[5:0]};
        end
        else if (cp[20:16] == '0)
        begin
            dec.last_idx = 2'd2;
            dec.bytes[0] = LEAD3_PFX | {4'b0000, cp[15:12]};
            dec.bytes[1] = CONT_PFX  | {2'b00, cp[11:6]};
            dec.bytes[2] = CONT_PFX  | {2'b00, cp[5:0]};
        end
        else
        begin
            dec.last_idx = 2'd3;
            dec.bytes[0] = LEAD4_PFX | {5'b00000, cp[20:18]};
            dec.bytes[1] = CONT_PFX  | {2'b00, cp[17:12]};
            dec.bytes[2] = CONT_PFX  | {2'b00, cp[11:6]};
            dec.bytes[3] = CONT_PFX  | {2'b00, cp[5:0]};
        end
    end

endmodule

// File: design/utf16_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder: UTF-16 code unit stream to UTF-8 byte stream
// Registers each unit, decodes it against the held surrogate and streams out
// the resulting bytes one per transaction with tlast on the final byte.
// ----------------------------------------------------------------------------
//  channel | dir | signals                       | content
//  s_      | in  | s_tvalid s_tready s_tdata[15:0] | code_unit
//  m_      | out | m_tvalid m_tready m_tdata[7:0]  | utf8_byte, tlast = last_byte
//
//  A unit is registered on input and decoded in the cycle it moves on; the
//  output group register then sends one byte per cycle while m_tready is
//  high. Units that give no bytes (surrogates held or dropped, units that
//  follow an unpaired high surrogate, terminator) leave the input register
//  without waiting on the output. Reset clears the valid flags and the held
//  surrogate. Output stalls back up into the input register, then drop s_tready.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_unit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] utf8_byte
    output logic        m_tlast
);
    import u16u8_pkg::*;

    logic                         in_valid_reg;
    logic [UNIT_W-1:0]            unit_reg;
    logic                         pend_reg;
    logic [HELD_W-1:0]            held_reg;
    logic                         grp_valid_reg;
    logic [SLOTS-1:0][BYTE_W-1:0] bytes_reg;
    logic [SLOT_W-1:0]            last_reg;
    logic [SLOT_W-1:0]            idx_reg;
    logic [SLOT_W-1:0]            idx_next;

    u16u8_dec_t                   dec;
    logic                         out_take;
    logic                         out_pop;
    logic                         grp_free;
    logic                         advance;
    logic                         load;
    logic                         s_take;

    u16u8_decode u_decode (
        .unit (unit_reg),
        .pend (pend_reg),
        .held (held_reg),
        .dec  (dec)
    );

    // Handshake bookkeeping
    assign out_take = grp_valid_reg && m_tready;
    assign out_pop  = out_take && (idx_reg == last_reg);
    assign grp_free = !grp_valid_reg || out_pop;
    assign advance  = in_valid_reg && (grp_free || !dec.emit);
    assign load     = advance && dec.emit;
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    // Drive the output byte
    assign m_tvalid = grp_valid_reg;
    assign m_tdata  = bytes_reg[idx_reg];
    assign m_tlast  = (idx_reg == last_reg);

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Capture the unit payload
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            unit_reg <= s_tdata;
        end
    end

    // Hold the pending high surrogate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            held_reg <= '0;
        end
        else if (advance)
        begin
            pend_reg <= dec.pend;
            held_reg <= dec.held;
        end
    end

    // Advance the byte index within the group
    always_comb
    begin
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = '0;
        end
        else if (out_take && !out_pop)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    // Output group register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                grp_valid_reg <= 1'b1;
            end
            else if (out_pop)
            begin
                grp_valid_reg <= 1'b0;
            end
        end
    end

    // Load the encoded bytes
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= dec.bytes;
            last_reg  <= dec.last_idx;
        end
    end

`ifndef ASSERT_OFF
    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg |-> (idx_reg <= last_reg))
        else $error("byte index ran past the end of its group");

    a_group_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_pop && !load) |=> !grp_valid_reg)
        else $error("group still valid after its final byte left");

    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (unit_reg == '0)) |=> !pend_reg)
        else $error("terminator did not clear the held surrogate");

    a_held_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_reg |-> (held_reg == '0))
        else $error("held surrogate bits nonzero with nothing pending");

    a_lead4: assert property (@(posedge clk) disable iff (!rst_n)
        (grp_valid_reg && (last_reg == 2'd3) && (idx_reg == 2'd0))
            |-> (m_tdata[7:3] == 5'b11110))
        else $error("four-byte group without a four-byte lead");
`endif

endmodule
